// ===== hdl/dhnt_pkg.sv =====
`default_nettype none

package dhnt_pkg;

  localparam int MAX_PARAMS = 4;
  localparam int VALUE_BITS = 32;
  localparam int PARAM_W    = $clog2(MAX_PARAMS + 1);

  localparam logic [4:0] CNT_LIMIT = 5'h1F;

  localparam logic [1:0] KIND_DEC  = 2'd0;
  localparam logic [1:0] KIND_HEX  = 2'd1;
  localparam logic [1:0] KIND_TEXT = 2'd2;

  typedef struct packed {
    logic [7:0] char_code;
    logic       line_start;
  } in_t;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  kind;
    logic [2:0]  slot;
    logic        stored;
    logic [7:0]  word_number;
  } out_t;

endpackage

`default_nettype wire

// ===== hdl/decimal_hex_number_tokenizer.sv =====
`default_nettype none
// A request is registered in the input register on acceptance, and its result, when the character
// ends a word, is registered into the output register as the held request steps on.
// Throughput: one character per cycle, set by the single tokenizer step between the
// input register and the output register; it stalls only while a result waits.
// Reset (synchronous, active high) clears the word state, both counts and all valids.

module decimal_hex_number_tokenizer (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire dhnt_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output dhnt_pkg::out_t      out_data
);

  logic           hold_valid;
  dhnt_pkg::in_t  hold_data;
  logic           step;
  logic           emit;
  dhnt_pkg::out_t result;

  // The held request moves on whenever the output register has room for a result.
  assign step     = hold_valid && (!out_valid || out_ready);
  assign in_ready = !hold_valid || step;

  dhnt_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (hold_data),
    .emit   (emit),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_ready) begin
        hold_valid <= in_valid;
      end
      if (step) begin
        out_valid <= emit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (in_valid && in_ready) begin
      hold_data <= in_data;
    end
    if (step && emit) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/dhnt_core.sv =====
`default_nettype none

module dhnt_core (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         step,
  input  wire dhnt_pkg::in_t item,
  output logic              emit,
  output dhnt_pkg::out_t    result
);

  logic [4:0]                      char_count;
  logic                            minus_seen;
  logic                            dec_excluded;
  logic                            not_hexadecimal;
  logic                            first_is_zero;
  logic [dhnt_pkg::VALUE_BITS-1:0] decimal_acc;
  logic [dhnt_pkg::VALUE_BITS-1:0] hex_acc;
  logic [dhnt_pkg::PARAM_W-1:0]    param_count;
  logic [7:0]                      word_count;

  logic [4:0]                      char_count_next;
  logic                            minus_seen_next;
  logic                            dec_excluded_next;
  logic                            not_hexadecimal_next;
  logic                            first_is_zero_next;
  logic [dhnt_pkg::VALUE_BITS-1:0] decimal_acc_next;
  logic [dhnt_pkg::VALUE_BITS-1:0] hex_acc_next;
  logic [dhnt_pkg::PARAM_W-1:0]    param_count_next;
  logic [7:0]                      word_count_next;

  logic [7:0]                      c;
  logic [7:0]                      uc;
  logic                            is_word;
  logic                            is_numeral;
  logic                            is_hex_letter;
  logic [3:0]                      digit_val;
  logic [3:0]                      hex_val;
  logic [dhnt_pkg::VALUE_BITS-1:0] dec_mac;
  logic [dhnt_pkg::VALUE_BITS-1:0] val;
  logic [1:0]                      kind;
  logic                            numeric;
  logic                            can_store;

  always_comb begin
    c             = item.char_code;
    is_word       = (c > 8'h20) && (c < 8'h80);
    uc            = ((c >= "a") && (c <= "z")) ? (c - 8'h20) : c;
    is_numeral    = (uc >= "0") && (uc <= "9");
    is_hex_letter = (uc >= "A") && (uc <= "F");
    digit_val     = 4'(uc - "0");
    hex_val       = is_numeral ? digit_val : 4'(uc - "A" + 8'd10);
    // Times ten as two shifted copies, plus the new digit.
    dec_mac       = (decimal_acc << 3) + (decimal_acc << 1)
                    + dhnt_pkg::VALUE_BITS'(digit_val);

    char_count_next      = char_count;
    minus_seen_next      = minus_seen;
    dec_excluded_next    = dec_excluded;
    not_hexadecimal_next = not_hexadecimal;
    first_is_zero_next   = first_is_zero;
    decimal_acc_next     = decimal_acc;
    hex_acc_next         = hex_acc;
    param_count_next     = item.line_start ? '0 : param_count;
    word_count_next      = item.line_start ? 8'd0 : word_count;

    emit      = 1'b0;
    val       = '0;
    kind      = dhnt_pkg::KIND_TEXT;
    numeric   = 1'b0;
    can_store = 1'b0;

    if (is_word) begin
      if (char_count == 5'd0) begin
        word_count_next    = word_count_next + 8'd1;
        first_is_zero_next = (c == "0");
      end
      if (char_count < dhnt_pkg::CNT_LIMIT) begin
        char_count_next = char_count + 5'd1;
      end
      if ((uc == "-") && (char_count_next == 5'd1)) begin
        minus_seen_next      = 1'b1;
        not_hexadecimal_next = 1'b1;
      end else if (!dec_excluded && is_numeral) begin
        decimal_acc_next = dec_mac;
        if (!not_hexadecimal) begin
          hex_acc_next = {hex_acc[dhnt_pkg::VALUE_BITS-5:0], digit_val};
        end
      end else if (!not_hexadecimal && (is_numeral || is_hex_letter)) begin
        dec_excluded_next = 1'b1;
        hex_acc_next      = {hex_acc[dhnt_pkg::VALUE_BITS-5:0], hex_val};
      end else if (!not_hexadecimal && first_is_zero_next && (uc == "X")
                   && (char_count_next == 5'd2)) begin
        dec_excluded_next = 1'b1;
      end else begin
        dec_excluded_next    = 1'b1;
        not_hexadecimal_next = 1'b1;
      end
    end else if (char_count != 5'd0) begin
      emit = 1'b1;
      if (!dec_excluded) begin
        val     = minus_seen ? (~decimal_acc + dhnt_pkg::VALUE_BITS'(1)) : decimal_acc;
        kind    = dhnt_pkg::KIND_DEC;
        numeric = 1'b1;
      end else if (!not_hexadecimal) begin
        val     = hex_acc;
        kind    = dhnt_pkg::KIND_HEX;
        numeric = 1'b1;
      end
      can_store = numeric
                  && (param_count_next < dhnt_pkg::PARAM_W'(dhnt_pkg::MAX_PARAMS));
      if (can_store) begin
        param_count_next = param_count_next + dhnt_pkg::PARAM_W'(1);
      end
      char_count_next      = 5'd0;
      minus_seen_next      = 1'b0;
      dec_excluded_next    = 1'b0;
      not_hexadecimal_next = 1'b0;
      first_is_zero_next   = 1'b0;
      decimal_acc_next     = '0;
      hex_acc_next         = '0;
    end

    result.value       = 32'(val);
    result.kind        = kind;
    result.slot        = 3'(item.line_start ? '0 : param_count);
    result.stored      = can_store;
    result.word_number = word_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count      <= 5'd0;
      minus_seen      <= 1'b0;
      dec_excluded    <= 1'b0;
      not_hexadecimal <= 1'b0;
      first_is_zero   <= 1'b0;
      decimal_acc     <= '0;
      hex_acc         <= '0;
      param_count     <= '0;
      word_count      <= 8'd0;
    end else if (step) begin
      char_count      <= char_count_next;
      minus_seen      <= minus_seen_next;
      dec_excluded    <= dec_excluded_next;
      not_hexadecimal <= not_hexadecimal_next;
      first_is_zero   <= first_is_zero_next;
      decimal_acc     <= decimal_acc_next;
      hex_acc         <= hex_acc_next;
      param_count     <= param_count_next;
      word_count      <= word_count_next;
    end
  end

endmodule

`default_nettype wire

// ===== dv/tb_decimal_hex_number_tokenizer.sv =====
module tb_decimal_hex_number_tokenizer;

  localparam int TARGET_CHARS = 1150;
  localparam int WRAP_WORDS   = 260;
  localparam int IDLE_LIMIT   = 1000;
  localparam int HOLD_CYCLES  = 80;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    dhnt_pkg::in_t data;
    bit            drain_first;
  } char_req_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           in_valid = 1'b0;
  logic           in_ready;
  dhnt_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  dhnt_pkg::out_t out_data;

  char_req_t      char_queue[$];
  dhnt_pkg::out_t token_queue[$];
  int        chars_queued = 0;
  int        chars_taken = 0;
  int        tokens_seen = 0;
  int        mismatches = 0;
  int        idle_cycles = 0;
  bit        char_taken = 1'b0;
  bit        drain_next = 1'b0;

  int unsigned tx_mode = 0;
  int unsigned tx_mode_left = 0;
  int unsigned tx_gap = 0;
  int unsigned rx_mode = 0;
  int unsigned rx_mode_left = 0;
  int unsigned rx_stall = 0;
  int unsigned hold_left = 0;
  int          next_hold = 30;

  // Shadow of the tokenizer state.
  logic [4:0]                   word_len;
  bit                           minus_seen;
  bit                           no_dec;
  bit                           no_hex;
  bit                           lead_zero;
  logic [31:0]                  dec_acc;
  logic [31:0]                  hex_acc;
  logic [dhnt_pkg::PARAM_W-1:0] params_held;
  logic [7:0]                   words_in_line;

  decimal_hex_number_tokenizer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int unsigned pick_gap(input int unsigned mode);
    int unsigned roll;
    roll = $urandom_range(99);
    if (mode == 0) return 0;
    if (roll < ((mode == 1) ? 80 : 40)) return 0;
    if (roll < 96) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  function automatic logic [7:0] pick_blank();
    if ($urandom_range(1) == 1) return 8'($urandom_range(32, 0));
    return 8'($urandom_range(255, 128));
  endfunction

  task automatic tokenize_char(input dhnt_pkg::in_t req, output bit has_token,
                               output dhnt_pkg::out_t token);
    logic [7:0] c;
    logic [7:0] uc;
    logic [3:0] nib;
    bit         is_dec;
    bit         is_hex;
    bit         numeric;
    has_token = 1'b0;
    numeric = 1'b0;
    token = '0;
    c = req.char_code;
    if (req.line_start) begin
      params_held = '0;
      words_in_line = '0;
    end
    if (c > 8'h20 && c < 8'h80) begin
      if (word_len == 0) begin
        words_in_line++;
        lead_zero = (c == "0");
      end
      if (word_len < dhnt_pkg::CNT_LIMIT) word_len++;
      uc = (c >= "a" && c <= "z") ? c - 8'h20 : c;
      is_dec = (uc >= "0" && uc <= "9");
      is_hex = is_dec || (uc >= "A" && uc <= "F");
      nib = is_dec ? 4'(uc - "0") : 4'(uc - "A" + 10);
      if (uc == "-" && word_len == 1) begin
        minus_seen = 1'b1;
        no_hex = 1'b1;
      end else if (!no_dec && is_dec) begin
        dec_acc = dec_acc * 10 + 32'(nib);
        if (!no_hex) hex_acc = {hex_acc[27:0], nib};
      end else if (!no_hex && is_hex) begin
        no_dec = 1'b1;
        hex_acc = {hex_acc[27:0], nib};
      end else if (!no_hex && lead_zero && uc == "X" && word_len == 2) begin
        no_dec = 1'b1;
      end else begin
        no_dec = 1'b1;
        no_hex = 1'b1;
      end
    end else if (word_len != 0) begin
      has_token = 1'b1;
      token.kind = dhnt_pkg::KIND_TEXT;
      if (!no_dec) begin
        token.value = minus_seen ? -dec_acc : dec_acc;
        token.kind = dhnt_pkg::KIND_DEC;
        numeric = 1'b1;
      end else if (!no_hex) begin
        token.value = hex_acc;
        token.kind = dhnt_pkg::KIND_HEX;
        numeric = 1'b1;
      end
      token.slot = 3'(params_held);
      token.stored = numeric && (params_held < dhnt_pkg::MAX_PARAMS);
      if (token.stored) params_held++;
      token.word_number = words_in_line;
      word_len = '0;
      minus_seen = 1'b0;
      no_dec = 1'b0;
      no_hex = 1'b0;
      lead_zero = 1'b0;
      dec_acc = '0;
      hex_acc = '0;
    end
  endtask

  task automatic push_char(input logic [7:0] code, input bit line_start);
    char_req_t req;
    req.data.char_code = code;
    req.data.line_start = line_start;
    req.drain_first = drain_next;
    drain_next = 1'b0;
    char_queue.push_back(req);
    chars_queued++;
  endtask

  task automatic push_text(input string s, input bit line_start);
    for (int i = 0; i < s.len(); i++) push_char(s[i], line_start && (i == 0));
  endtask

  task automatic add_random_word();
    string      hex_set;
    string      mix_set;
    int         sel;
    int         len;
    int         blanks;
    logic [7:0] c;
    hex_set = "0123456789abcdefABCDEF";
    mix_set = "0123456789abcdefABCDEFxX-g";
    sel = $urandom_range(99);
    len = ($urandom_range(9) == 0) ? $urandom_range(40, 11) : $urandom_range(10, 1);
    if (sel < 30) begin
      if ($urandom_range(1) == 1) push_char("-", $urandom_range(99) < 3);
      for (int i = 0; i < len; i++) push_char(8'("0" + $urandom_range(9)), $urandom_range(99) < 3);
    end else if (sel < 60) begin
      if ($urandom_range(1) == 1) begin
        push_char("0", $urandom_range(99) < 3);
        push_char(($urandom_range(1) == 1) ? "x" : "X", $urandom_range(99) < 3);
      end
      for (int i = 0; i < len; i++) begin
        c = hex_set[$urandom_range(hex_set.len() - 1)];
        push_char(c, $urandom_range(99) < 3);
      end
    end else if (sel < 75) begin
      for (int i = 0; i < len; i++) push_char(8'($urandom_range(127, 33)), $urandom_range(99) < 3);
    end else begin
      // Short words over a numeric alphabet: stray minus signs, misplaced x, bad digits.
      len = $urandom_range(6, 1);
      for (int i = 0; i < len; i++) begin
        c = mix_set[$urandom_range(mix_set.len() - 1)];
        push_char(c, $urandom_range(99) < 3);
      end
    end
    blanks = ($urandom_range(9) == 0) ? $urandom_range(4, 2) : 1;
    for (int i = 0; i < blanks; i++) push_char(pick_blank(), $urandom_range(99) < 3);
  endtask

  // Request driver.
  always @(negedge clk) begin
    char_req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (tx_mode_left == 0) begin
        tx_mode = $urandom_range(2);
        tx_mode_left = $urandom_range(80, 20);
      end else begin
        tx_mode_left--;
      end
      if (in_valid && !char_taken) begin
        // The offered request has not been taken yet, so it stays put.
      end else if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (char_queue.size() != 0 &&
                   !(char_queue[0].drain_first && token_queue.size() != 0)) begin
        nxt = char_queue.pop_front();
        in_data <= nxt.data;
        in_valid <= 1'b1;
        tx_gap = (hold_left > 0) ? 0 : pick_gap(tx_mode);
      end else begin
        in_valid <= 1'b0;
      end
      char_taken = 1'b0;
    end
  end

  // Result receiver with random stalls and two long hold-offs.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_left == 0 && next_hold > 0 && tokens_seen >= next_hold) begin
        hold_left = HOLD_CYCLES;
        next_hold = (next_hold == 30) ? 250 : 0;
      end
      if (rx_mode_left == 0) begin
        rx_mode = $urandom_range(2);
        rx_mode_left = $urandom_range(80, 20);
      end else begin
        rx_mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        rx_stall = pick_gap(rx_mode);
      end
    end
  end

  // Monitor: checks results against the predicted tokens, then predicts for new requests.
  always @(posedge clk) begin
    bit             has_token;
    dhnt_pkg::out_t token;
    dhnt_pkg::out_t want;
    if (rst) begin
      word_len = '0;
      minus_seen = 1'b0;
      no_dec = 1'b0;
      no_hex = 1'b0;
      lead_zero = 1'b0;
      dec_acc = '0;
      hex_acc = '0;
      params_held = '0;
      words_in_line = '0;
    end else begin
      if (out_valid && out_ready) begin
        tokens_seen++;
        if (token_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected token: value %h kind %0d slot %0d stored %0d word %0d",
                     out_data.value, out_data.kind, out_data.slot, out_data.stored,
                     out_data.word_number);
        end else begin
          want = token_queue.pop_front();
          if (out_data.value !== want.value || out_data.kind !== want.kind ||
              out_data.slot !== want.slot || out_data.stored !== want.stored ||
              out_data.word_number !== want.word_number) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("token %0d expected: value %h kind %0d slot %0d stored %0d word %0d",
                       tokens_seen, want.value, want.kind, want.slot, want.stored,
                       want.word_number);
              $display("token %0d actual:   value %h kind %0d slot %0d stored %0d word %0d",
                       tokens_seen, out_data.value, out_data.kind, out_data.slot,
                       out_data.stored, out_data.word_number);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        char_taken = 1'b1;
        chars_taken++;
        tokenize_char(in_data, has_token, token);
        if (has_token) token_queue.push_back(token);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: %0d cycles without a handshake", idle_cycles);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    // Directed line: minus, bare 0x, mixed-case hex, lone minus, a fifth number
    // with the parameters full, a text word, a stray blank, then a line start
    // in the middle of a word.
    push_text("-1", 1'b1);
    push_char(8'h20, 1'b0);
    push_text("0x", 1'b0);
    push_char(8'h00, 1'b0);
    push_text("aF", 1'b0);
    push_char(8'h80, 1'b0);
    push_text("-", 1'b0);
    push_char(8'h1F, 1'b0);
    push_text("99", 1'b0);
    push_char(8'hFF, 1'b0);
    push_char(8'h7E, 1'b0);
    push_char(8'h21, 1'b0);
    push_char(8'h7F, 1'b0);
    push_char(8'h0A, 1'b0);
    push_char(8'h20, 1'b0);
    push_char("5", 1'b0);
    push_char("5", 1'b1);
    push_char(8'h20, 1'b0);

    while (chars_queued < 400) add_random_word();

    // One long line of short words so the word number wraps.
    drain_next = 1'b1;
    for (int w = 0; w < WRAP_WORDS; w++) begin
      push_char(8'($urandom_range(127, 33)), w == 0);
      push_char(pick_blank(), 1'b0);
    end

    drain_next = 1'b1;
    while (chars_queued < TARGET_CHARS) add_random_word();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (chars_taken < chars_queued || token_queue.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
